/* sv/ple_pkg.sv */
// Shared constants, codes and result type of the positional list engine.
`default_nettype none

package ple_pkg;

    // Default list capacity in entries.
    localparam int CAPACITY_DEF = 64;

    // Field widths.
    localparam int ACT_W   = 2;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int LEN_W   = 7;
    localparam int TDATA_W = 48;

    // Request codes.
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd3;

    // Status codes.
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // One result word, handed from the sequencer to the output register.
    typedef struct packed {
        logic [LEN_W-1:0]        list_length;
        logic [ST_W-1:0]         status;
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
    } res_t;

endpackage

`default_nettype wire

/* sv/ple_ram.sv */
// Entry store of the positional list engine: one write port, one registered read port.
`default_nettype none

module ple_ram #(
    parameter int DEPTH = ple_pkg::CAPACITY_DEF,
    parameter int AW    = 6
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [ple_pkg::VAL_W-1:0]  wr_data,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [ple_pkg::VAL_W-1:0]  rd_data
);

    logic [ple_pkg::VAL_W-1:0] mem [0:DEPTH-1];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/ple_seq.sv */
// Request sequencer of the positional list engine: shifts, scans and reads the entry store.
`default_nettype none

module ple_seq #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [ple_pkg::ACT_W-1:0]  in_action,
    input  wire logic [ple_pkg::POS_W-1:0]  in_position,
    input  wire logic [ple_pkg::VAL_W-1:0]  in_value,
    input  wire logic                       out_free,
    output logic                            res_valid,
    output ple_pkg::res_t                   res
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        pend_reg, pend_next;
    logic [AW-1:0]               pend_addr_reg, pend_addr_next;
    logic [AW-1:0]               src_reg, src_next;
    logic [AW-1:0]               end_reg, end_next;
    logic                        found_reg, found_next;
    logic [ple_pkg::ACT_W-1:0]   act_reg, act_next;
    logic [ple_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [ple_pkg::VAL_W-1:0]   val_reg, val_next;
    logic [ple_pkg::ST_W-1:0]    st_reg, st_next;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [ple_pkg::VAL_W-1:0]   wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [ple_pkg::VAL_W-1:0]   rd_data;

    logic [CMP_W-1:0]            pos_ext;
    logic [CMP_W-1:0]            cnt_ext;
    logic [CW-1:0]               cnt_done;
    logic                        accept;

    ple_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign pos_ext  = CMP_W'(in_position);
    assign cnt_ext  = CMP_W'(cnt_reg);

    // Length after the request, applied only when it completes without error.
    always_comb begin
        cnt_done = cnt_reg;
        if (st_reg == ple_pkg::ST_DONE) begin
            if (act_reg == ple_pkg::ACT_INSERT) begin
                cnt_done = cnt_reg + CW'(1);
            end else if (act_reg == ple_pkg::ACT_DELETE) begin
                cnt_done = cnt_reg - CW'(1);
            end
        end
    end

    // Store write port: a pending shift move has priority; the final insert write
    // happens only in the finish state, after every move has landed.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = rd_data;
        if (pend_reg && (act_reg != ple_pkg::ACT_SEARCH)) begin
            wr_en = 1'b1;
        end else if ((state_reg == S_FIN) && (act_reg == ple_pkg::ACT_INSERT) &&
                     (st_reg == ple_pkg::ST_DONE)) begin
            wr_en   = 1'b1;
            wr_addr = AW'(pos_reg);
            wr_data = val_reg;
        end
    end

    // Result word.
    always_comb begin
        res.list_length = ple_pkg::LEN_W'(cnt_done);
        res.status      = st_reg;
        res.found       = found_reg;
        res.read_value  = '0;
        if ((act_reg == ple_pkg::ACT_READ) && (st_reg == ple_pkg::ST_DONE)) begin
            res.read_value = rd_data;
        end
    end

    assign res_valid = (state_reg == S_FIN) && out_free;

    // Sequencer next state.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        src_next       = src_reg;
        end_next       = end_reg;
        found_next     = found_reg;
        act_next       = act_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        rd_en          = 1'b0;
        rd_addr        = src_reg;

        // A returned word is compared during a scan.
        if (pend_reg && (act_reg == ple_pkg::ACT_SEARCH) && (rd_data == val_reg)) begin
            found_next = 1'b1;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    act_next   = in_action;
                    pos_next   = in_position;
                    val_next   = in_value;
                    found_next = 1'b0;
                    st_next    = ple_pkg::ST_DONE;
                    state_next = S_FIN;
                    case (in_action)
                        ple_pkg::ACT_INSERT: begin
                            if (pos_ext > cnt_ext) begin
                                st_next = ple_pkg::ST_RANGE;
                            end else if (cnt_ext == CMP_W'(CAPACITY)) begin
                                st_next = ple_pkg::ST_FULL;
                            end else if (pos_ext != cnt_ext) begin
                                // Move entries from the tail down to the position up by one.
                                src_next   = AW'(cnt_reg - CW'(1));
                                end_next   = AW'(in_position);
                                state_next = S_SHIFT;
                            end
                        end
                        ple_pkg::ACT_DELETE: begin
                            if (pos_ext >= cnt_ext) begin
                                st_next = ple_pkg::ST_RANGE;
                            end else if ((pos_ext + CMP_W'(1)) != cnt_ext) begin
                                // Move entries above the position down by one.
                                src_next   = AW'(pos_ext + CMP_W'(1));
                                end_next   = AW'(cnt_reg - CW'(1));
                                state_next = S_SHIFT;
                            end
                        end
                        ple_pkg::ACT_READ: begin
                            if (pos_ext >= cnt_ext) begin
                                st_next = ple_pkg::ST_RANGE;
                            end else begin
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            // Search scans every valid entry from the head.
                            if (cnt_reg != '0) begin
                                src_next   = '0;
                                end_next   = AW'(cnt_reg - CW'(1));
                                state_next = S_SHIFT;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // One read per cycle; its word is written back or compared next cycle.
                rd_en     = 1'b1;
                pend_next = 1'b1;
                if (act_reg == ple_pkg::ACT_INSERT) begin
                    pend_addr_next = src_reg + AW'(1);
                end else begin
                    pend_addr_next = src_reg - AW'(1);
                end
                if (src_reg == end_reg) begin
                    state_next = S_DRAIN;
                end else if (act_reg == ple_pkg::ACT_INSERT) begin
                    src_next = src_reg - AW'(1);
                end else begin
                    src_next = src_reg + AW'(1);
                end
            end
            S_DRAIN: begin
                // The last read word is handled here.
                state_next = S_FIN;
            end
            S_READ: begin
                rd_en      = 1'b1;
                rd_addr    = AW'(pos_reg);
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    cnt_next   = cnt_done;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    // Request and scan payload.
    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        src_reg       <= src_next;
        end_reg       <= end_next;
        found_reg     <= found_next;
        act_reg       <= act_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        st_reg        <= st_next;
    end

endmodule

`default_nettype wire

/* sv/positional_list_engine_top.sv */
// Top level of the positional list engine: stream ports and output register.
//
// Usage: requests arrive as words on the s_ channel, results leave as words on the
// m_ channel, exactly one result word per request, in request order.
// A request is taken when s_tvalid and s_tready are both high; s_tready is high
// whenever no request is in progress, even while a result still waits on m_.
// Each request runs alone against a single-port-per-direction entry store, so its
// duration depends on the work it does: a read or a refused request moves no entry;
// an insert moves each entry from its position to the tail up by one, and a delete
// moves each entry above its position down by one, so an insert at the end of the
// list or a delete of the last entry moves none; a search scans the whole list.
// The worst case is a search of a full list.
// Results sit in an output register; if the receiver holds m_tready low, the next
// finished request waits in the sequencer and no further request is taken.
// Reset (aresetn low at a clock edge) empties the list and drops any request in
// flight or result not yet taken; no store clearing pass is needed.
`default_nettype none

module positional_list_engine_top #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // s_tdata: action [1:0], position [8:2], value [40:9], zero fill [47:41]
    input  wire logic [ple_pkg::TDATA_W-1:0]  s_tdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // m_tdata: read_value [31:0], found [32], status [34:33], list_length [41:35],
    // zero fill [47:42]
    output logic      [ple_pkg::TDATA_W-1:0]  m_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready
);

    localparam int RES_W = $bits(ple_pkg::res_t);

    logic          out_free;
    logic          res_valid;
    ple_pkg::res_t res;
    logic          m_valid_reg, m_valid_next;
    ple_pkg::res_t m_data_reg, m_data_next;

    assign out_free = !m_valid_reg || m_tready;

    ple_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tdata[1:0]),
        .in_position (s_tdata[8:2]),
        .in_value    (s_tdata[40:9]),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output register: loads a finished result when empty or being taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ple_pkg::TDATA_W - RES_W){1'b0}}, m_data_reg};

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the positional list engine: stimulus, list predictor and checker.

module testbench;
    import ple_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 10;
    localparam int RANDOM_ITEMS    = 630;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = CAPACITY_DEF + 16;
    localparam int REPORT_LIMIT    = 10;
    localparam int TIMEOUT_NS      = 6_000_000;
    localparam int FILL_W          = TDATA_W - ACT_W - POS_W - VAL_W;

    // Mix of requests used by the random part.
    typedef enum {GROW_PHASE, SHRINK_PHASE, MIXED_PHASE} mix_phase_t;

    // One row of the directed table.
    typedef struct {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
        bit               typed;
        res_t             want;
    } request_row_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tvalid = 1'b0;
    wire                s_tready;
    wire  [TDATA_W-1:0] m_tdata;
    wire                m_tvalid;
    logic               m_tready = 1'b0;

    // Predicted list contents and length.
    logic [VAL_W-1:0] list_model [CAPACITY_DEF];
    int               list_len = 0;

    // Results still owed by the block, oldest first.
    res_t             pending_results [$];
    request_row_t     directed_rows [$];

    int  mismatch_count  = 0;
    int  burst_left      = 0;
    bit  hold_off_req    = 1'b0;
    bit  hold_off_done   = 1'b0;
    int  hold_off_left   = 0;
    int  stall_mode      = 0;
    int  stall_mode_left = 0;
    int  pattern_phase   = 0;
    res_t observed;
    res_t oldest;

    positional_list_engine_top #(
        .CAPACITY (CAPACITY_DEF)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Applies one request to the predicted list and returns the result it should produce.
    function automatic res_t predict_request(input logic [ACT_W-1:0] action,
                                             input logic [POS_W-1:0] position,
                                             input logic [VAL_W-1:0] value);
        res_t outcome;
        int   i;
        int   where;
        outcome = '0;
        where = int'(position);
        outcome.status = ST_DONE;
        case (action)
            ACT_INSERT: begin
                if (where > list_len) begin
                    outcome.status = ST_RANGE;
                end else if (list_len >= CAPACITY_DEF) begin
                    outcome.status = ST_FULL;
                end else begin
                    for (i = list_len; i > where; i--)
                        list_model[i] = list_model[i-1];
                    list_model[where] = value;
                    list_len++;
                end
            end
            ACT_DELETE: begin
                if (where >= list_len) begin
                    outcome.status = ST_RANGE;
                end else begin
                    for (i = where; i + 1 < list_len; i++)
                        list_model[i] = list_model[i+1];
                    list_len--;
                end
            end
            ACT_READ: begin
                if (where >= list_len)
                    outcome.status = ST_RANGE;
                else
                    outcome.read_value = list_model[where];
            end
            default: begin
                // Search ignores the position and always completes.
                for (i = 0; i < list_len; i++) begin
                    if (list_model[i] == value)
                        outcome.found = 1'b1;
                end
            end
        endcase
        outcome.list_length = list_len[LEN_W-1:0];
        return outcome;
    endfunction

    // Builds a result from its fields, for the typed-in rows of the table.
    function automatic res_t outcome_of(input int len, input logic [ST_W-1:0] status,
                                        input logic found, input logic [VAL_W-1:0] read_value);
        res_t r;
        r.list_length = len[LEN_W-1:0];
        r.status      = status;
        r.found       = found;
        r.read_value  = read_value;
        return r;
    endfunction

    task automatic add_row(input logic [ACT_W-1:0] action, input int position,
                           input logic [VAL_W-1:0] value, input bit typed, input res_t want);
        request_row_t row;
        row.action   = action;
        row.position = position[POS_W-1:0];
        row.value    = value;
        row.typed    = typed;
        row.want     = want;
        directed_rows.push_back(row);
    endtask

    // Offers one request word, idling between bursts, and records its expected result
    // once the block has taken it.
    task automatic offer_request(input logic [ACT_W-1:0] action,
                                 input logic [POS_W-1:0] position,
                                 input logic [VAL_W-1:0] value,
                                 input bit typed, input res_t typed_want);
        res_t want;
        want = predict_request(action, position, value);
        if (typed)
            want = typed_want;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tdata  <= {{FILL_W{1'b0}}, value, position, action};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results.push_back(want);
    endtask

    // Result side: check each word taken, then choose the ready level for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            observed = m_tdata[$bits(res_t)-1:0];
            if (pending_results.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result word: rd=%h fnd=%0d st=%0d len=%0d",
                             observed.read_value, observed.found, observed.status,
                             observed.list_length);
                mismatch_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (observed.read_value !== oldest.read_value ||
                    observed.found !== oldest.found ||
                    observed.status !== oldest.status ||
                    observed.list_length !== oldest.list_length) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("result mismatch: got rd=%h fnd=%0d st=%0d len=%0d, expected rd=%h fnd=%0d st=%0d len=%0d",
                                 observed.read_value, observed.found, observed.status,
                                 observed.list_length, oldest.read_value, oldest.found,
                                 oldest.status, oldest.list_length);
                    mismatch_count++;
                end
            end
        end

        // One long hold-off so that the block backs up and stalls its input.
        if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_tready <= 1'b0;
        end else begin
            if (stall_mode_left == 0) begin
                stall_mode      = $urandom_range(0, 3);
                stall_mode_left = $urandom_range(20, 200);
            end else begin
                stall_mode_left--;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: begin
                    m_tready <= (pattern_phase == 0);
                    pattern_phase = (pattern_phase + 1) % 3;
                end
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Main sequence: reset, directed table, random requests, drain and verdict.
    initial begin
        mix_phase_t       mix;
        int               mix_left;
        int               n;
        int               roll;
        int               span;
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;

        mix      = GROW_PHASE;
        mix_left = $urandom_range(90, 150);

        // Empty list: the positional requests below are refused; the search completes.
        add_row(ACT_READ,   0,  32'h0000_0000, 1'b1, outcome_of(0, ST_RANGE, 1'b0, '0));
        add_row(ACT_DELETE, 0,  32'h0000_0000, 1'b1, outcome_of(0, ST_RANGE, 1'b0, '0));
        add_row(ACT_SEARCH, 5,  32'h0000_0000, 1'b1, outcome_of(0, ST_DONE,  1'b0, '0));
        add_row(ACT_INSERT, 1,  32'h0000_0005, 1'b1, outcome_of(0, ST_RANGE, 1'b0, '0));
        // Build the list 80000000, 0, 7fffffff, ffffffff.
        add_row(ACT_INSERT, 0,  32'h7FFF_FFFF, 1'b1, outcome_of(1, ST_DONE,  1'b0, '0));
        add_row(ACT_INSERT, 0,  32'h8000_0000, 1'b1, outcome_of(2, ST_DONE,  1'b0, '0));
        add_row(ACT_INSERT, 2,  32'hFFFF_FFFF, 1'b1, outcome_of(3, ST_DONE,  1'b0, '0));
        add_row(ACT_INSERT, 1,  32'h0000_0000, 1'b1, outcome_of(4, ST_DONE,  1'b0, '0));
        add_row(ACT_READ,   0,  32'h0000_0000, 1'b1,
                outcome_of(4, ST_DONE, 1'b0, 32'h8000_0000));
        add_row(ACT_READ,   3,  32'h0000_0000, 1'b1,
                outcome_of(4, ST_DONE, 1'b0, 32'hFFFF_FFFF));
        // Positions at and beyond the length.
        add_row(ACT_READ,   4,  32'h0000_0000, 1'b1, outcome_of(4, ST_RANGE, 1'b0, '0));
        add_row(ACT_READ,   64, 32'hFFFF_FFFF, 1'b1, outcome_of(4, ST_RANGE, 1'b0, '0));
        add_row(ACT_INSERT, 64, 32'h1234_5678, 1'b1, outcome_of(4, ST_RANGE, 1'b0, '0));
        add_row(ACT_DELETE, 64, 32'h0000_0000, 1'b1, outcome_of(4, ST_RANGE, 1'b0, '0));
        // Searches, deletes at head, tail and middle, a read, inserts at the end and at the head.
        add_row(ACT_SEARCH, 64, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(ACT_SEARCH, 0,  32'hFFFF_FFFF, 1'b0, '0);
        add_row(ACT_SEARCH, 3,  32'h0000_0001, 1'b0, '0);
        add_row(ACT_DELETE, 0,  32'h0000_0000, 1'b0, '0);
        add_row(ACT_DELETE, 2,  32'h0000_0000, 1'b0, '0);
        add_row(ACT_READ,   1,  32'h0000_0000, 1'b0, '0);
        add_row(ACT_INSERT, 2,  32'h1234_5678, 1'b0, '0);
        add_row(ACT_DELETE, 1,  32'h0000_0000, 1'b0, '0);
        add_row(ACT_INSERT, 0,  32'h7FFF_FFFF, 1'b0, '0);
        add_row(ACT_SEARCH, 0,  32'h7FFF_FFFF, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[k])
            offer_request(directed_rows[k].action, directed_rows[k].position,
                          directed_rows[k].value, directed_rows[k].typed,
                          directed_rows[k].want);

        // Random part: alternate growing, shrinking and mixed stretches.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (mix_left == 0) begin
                case (mix)
                    GROW_PHASE:   mix = MIXED_PHASE;
                    MIXED_PHASE:  mix = SHRINK_PHASE;
                    default:      mix = GROW_PHASE;
                endcase
                mix_left = $urandom_range(60, 140);
            end
            mix_left--;
            if (n == RANDOM_ITEMS / 3)
                hold_off_req = 1'b1;

            roll = $urandom_range(0, 99);
            case (mix)
                GROW_PHASE:
                    action = (roll < 70) ? ACT_INSERT : (roll < 80) ? ACT_DELETE :
                             (roll < 90) ? ACT_READ : ACT_SEARCH;
                SHRINK_PHASE:
                    action = (roll < 15) ? ACT_INSERT : (roll < 70) ? ACT_DELETE :
                             (roll < 85) ? ACT_READ : ACT_SEARCH;
                default:
                    action = (roll < 25) ? ACT_INSERT : (roll < 50) ? ACT_DELETE :
                             (roll < 75) ? ACT_READ : ACT_SEARCH;
            endcase

            // Mostly valid positions, weighted toward both ends, with some out of range.
            roll = $urandom_range(0, 99);
            span = (action == ACT_INSERT) ? list_len : list_len - 1;
            if (roll < 10 || span < 0)
                position = POS_W'($urandom_range(0, CAPACITY_DEF));
            else if (roll < 25)
                position = '0;
            else if (roll < 40)
                position = span[POS_W-1:0];
            else
                position = POS_W'($urandom_range(0, span));

            // Searches often look for a value that is present.
            roll = $urandom_range(0, 99);
            if (action == ACT_SEARCH && list_len > 0 && roll < 60)
                value = list_model[$urandom_range(0, list_len - 1)];
            else if (roll < 70)
                value = $urandom;
            else if (roll < 78)
                value = 32'h7FFF_FFFF;
            else if (roll < 86)
                value = 32'h8000_0000;
            else if (roll < 90)
                value = 32'h0000_0000;
            else if (roll < 94)
                value = 32'hFFFF_FFFF;
            else
                value = $urandom_range(0, 15);

            offer_request(action, position, value, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every owed result, then watch for stray words.
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("positional_list_engine_top verification clean");
        end else begin
            $display("positional_list_engine_top verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("positional_list_engine_top verification failed");
        $finish;
    end

endmodule
